FILE: rtl/core/psgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgc_pkg
// Types and constants for the phase shift / Gray code unwrap pipeline.
// ----------------------------------------------------------------------------
package psgc_pkg;
	localparam int PIXEL_BITS   = 8;
	localparam int CORDIC_STEPS = 24;
	localparam int CW           = PIXEL_BITS + 28;  // CORDIC datapath width
	localparam int ZW           = 26;               // angle accumulator width
	localparam int SUMW         = PIXEL_BITS + 2;
	localparam int MSQW         = 2 * PIXEL_BITS + 2;

	localparam logic signed [18:0] Q_PI         = 19'sd205887;
	localparam logic signed [18:0] Q_HALF_PI    = 19'sd102944;
	localparam logic signed [18:0] Q_QUARTER_PI = 19'sd51472;
	localparam logic signed [31:0] Q_TWO_PI     = 32'sd411775;
	localparam logic signed [31:0] Q_32PI       = 32'sd6588397;
	localparam logic signed [31:0] ABS_MAX      = 32'sd134217727;
	localparam logic signed [31:0] ABS_MIN      = -32'sd134217728;

	localparam logic [1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [1:0] REG_REF_ENABLE = 2'd1;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	typedef struct packed {
		pix_t [3:0]         ps;
		pix_t [5:0]         gs;
		logic signed [27:0] ref_ph;
	} pixel_t;

	// side data that rides along the CORDIC cells
	typedef struct packed {
		logic               zero;
		logic               swap;
		logic               xneg;
		logic               yneg;
		logic [SUMW-1:0]    sum;
		logic [MSQW-1:0]    msq;
		logic [5:0]         gv;
		logic signed [27:0] ref_ph;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 26'sd13176795;
			1: r = 26'sd7778716;
			2: r = 26'sd4110060;
			3: r = 26'sd2086331;
			4: r = 26'sd1047214;
			5: r = 26'sd524117;
			6: r = 26'sd262123;
			7: r = 26'sd131069;
			default: r = ZW'(26'sd1 <<< (24 - i));
		endcase
		return r;
	endfunction
endpackage

FILE: rtl/core/psgc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgc_in_if / psgc_out_if
// Valid/ready channels carrying one pixel transaction or one result.
// ----------------------------------------------------------------------------
interface psgc_in_if;
	import psgc_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIXEL_BITS-1:0] phase_sample_0, phase_sample_1, phase_sample_2, phase_sample_3;
	logic [PIXEL_BITS-1:0] gray_sample_0, gray_sample_1, gray_sample_2;
	logic [PIXEL_BITS-1:0] gray_sample_3, gray_sample_4, gray_sample_5;
	logic signed [27:0] ref_phase;
	modport source (output valid, phase_sample_0, phase_sample_1, phase_sample_2,
		phase_sample_3, gray_sample_0, gray_sample_1, gray_sample_2, gray_sample_3,
		gray_sample_4, gray_sample_5, ref_phase, input ready);
	modport sink (input valid, phase_sample_0, phase_sample_1, phase_sample_2,
		phase_sample_3, gray_sample_0, gray_sample_1, gray_sample_2, gray_sample_3,
		gray_sample_4, gray_sample_5, ref_phase, output ready);
endinterface

interface psgc_out_if;
	logic               valid;
	logic               ready;
	logic signed [27:0] absolute_phase;
	logic signed [18:0] wrapped_phase;
	logic [9:0]         texture_sum;
	logic [16:0]        modulation_sq;
	logic               modulation_ok;
	modport source (output valid, absolute_phase, wrapped_phase, texture_sum,
		modulation_sq, modulation_ok, input ready);
	modport sink (input valid, absolute_phase, wrapped_phase, texture_sum,
		modulation_sq, modulation_ok, output ready);
endinterface

FILE: rtl/core/psgc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgc_cell
// One CORDIC vectoring iteration with its pipeline register.
// ----------------------------------------------------------------------------
module psgc_cell import psgc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [4:0] step,
	input  logic       vld_in,
	input  cordic_t    cd_in,
	input  side_t      sd_in,
	output logic       vld_q,
	output cordic_t    cd_q,
	output side_t      sd_q
);
	cordic_t nxt;
	always_comb begin
		nxt = cd_in;
		if (!cd_in.y[CW-1]) begin
			nxt.x = cd_in.x + (cd_in.y >>> step);
			nxt.y = cd_in.y - (cd_in.x >>> step);
			nxt.z = cd_in.z + atan_entry(int'(step));
		end else begin
			nxt.x = cd_in.x - (cd_in.y >>> step);
			nxt.y = cd_in.y + (cd_in.x >>> step);
			nxt.z = cd_in.z - atan_entry(int'(step));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_in;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cd_q <= nxt;
			sd_q <= sd_in;
		end
	end
endmodule

FILE: rtl/core/psgc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgc_front
// Sums, differences, modulation, Gray binarize/decode, octant fold.
// ----------------------------------------------------------------------------
module psgc_front import psgc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    vld_in,
	input  pixel_t  px,
	output logic    vld_s1,
	output cordic_t cd_s1,
	output side_t   sd_s1
);
	logic [SUMW-1:0]           sum;
	logic signed [PIXEL_BITS:0] di, dq;
	logic [PIXEL_BITS-1:0]     ax, ay;
	logic [MSQW-1:0]           msq;
	logic [5:0]                gv;
	logic                      bitv;
	side_t                     sd;
	cordic_t                   cd;

	always_comb begin
		sum = SUMW'(px.ps[0]) + SUMW'(px.ps[1]) + SUMW'(px.ps[2]) + SUMW'(px.ps[3]);
		di  = $signed({1'b0, px.ps[3]}) - $signed({1'b0, px.ps[1]});
		dq  = $signed({1'b0, px.ps[0]}) - $signed({1'b0, px.ps[2]});
		ay  = di[PIXEL_BITS] ? PIXEL_BITS'(-di) : di[PIXEL_BITS-1:0];
		ax  = dq[PIXEL_BITS] ? PIXEL_BITS'(-dq) : dq[PIXEL_BITS-1:0];
		msq = MSQW'(ax) * MSQW'(ax) + MSQW'(ay) * MSQW'(ay);
		bitv = 1'b0;
		for (int i = 0; i < 6; i++) begin
			bitv = bitv ^ ({px.gs[i], 2'b00} >= sum);
			gv[5-i] = bitv;
		end
		sd.zero   = (ax == '0) && (ay == '0);
		sd.swap   = ay > ax;
		sd.xneg   = dq[PIXEL_BITS];
		sd.yneg   = di[PIXEL_BITS];
		sd.sum    = sum;
		sd.msq    = msq;
		sd.gv     = gv;
		sd.ref_ph = px.ref_ph;
		cd.x = sd.swap ? {{(CW-PIXEL_BITS-24){1'b0}}, ay, 24'd0}
		               : {{(CW-PIXEL_BITS-24){1'b0}}, ax, 24'd0};
		cd.y = sd.swap ? {{(CW-PIXEL_BITS-24){1'b0}}, ax, 24'd0}
		               : {{(CW-PIXEL_BITS-24){1'b0}}, ay, 24'd0};
		cd.z = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= vld_in;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cd_s1 <= cd;
			sd_s1 <= sd;
		end
	end
endmodule

FILE: rtl/core/psgc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgc_back
// Angle rounding and mirroring, unwrap, reference correction, mask.
// ----------------------------------------------------------------------------
module psgc_back import psgc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  cordic_t            cd,
	input  side_t              sd,
	input  logic [7:0]         thr,
	input  logic               ref_en,
	output logic               vld_s3,
	output logic signed [27:0] abs_s3,
	output logic signed [18:0] wrp_s3,
	output logic [9:0]         sum_s3,
	output logic [16:0]        msq_s3,
	output logic               ok_s3
);
	// stage 1: wrapped phase, unwrap offset product
	logic signed [ZW-1:0] zc;
	logic signed [19:0]   q, a, w;
	logic [5:0]           k1, k2;
	logic signed [7:0]    kk;
	logic signed [31:0]   d0;
	logic [15:0]          thr_sq;
	logic                 vld_s1, ok_s1, ok_s2, ref_en_s1;
	logic signed [31:0]   d_s1, ref_s1, d_s2;
	logic signed [18:0]   w_s1, w_s2;
	side_t                sd_s1, sd_s2;
	logic                 vld_s2;
	// stage 2 / 3
	logic signed [28:0]   diff, diff_s2;
	logic signed [47:0]   prod;
	logic signed [5:0]    qq, qq_s2;
	logic signed [31:0]   qm, rem, e, d3;

	always_comb begin
		zc = cd.z[ZW-1] ? '0 : cd.z;
		q  = 20'((zc + 26'sd128) >>> 8);
		if (q > 20'(Q_QUARTER_PI)) q = 20'(Q_QUARTER_PI);
		a = sd.swap ? 20'(Q_HALF_PI) - q : q;
		if (sd.xneg) a = 20'(Q_PI) - a;
		if (sd.yneg) a = -a;
		w = sd.zero ? '0 : a;
		k1 = {1'b0, sd.gv[5:1]};
		k2 = 6'((7'(sd.gv) + 7'd1) >> 1);
		if (w <= -20'(Q_HALF_PI))   kk = 8'(k2);
		else if (w >= 20'(Q_HALF_PI)) kk = 8'(k2) - 8'sd1;
		else kk = 8'(k1);
		d0 = 32'(w) + Q_TWO_PI * 32'(kk);
		thr_sq = 16'(thr) * 16'(thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in; vld_s2 <= vld_s1; vld_s3 <= vld_s2;
		end
	end

	// floor((ref - d) / 32pi) by reciprocal 2^40 / 32pi; estimate is off by at most one
	always_comb begin
		diff = 29'(ref_s1 - d_s1);
		prod = 48'(diff) * 48'sd166886;
		qq   = 6'(prod >>> 40);
	end

	// remainder check fixes the estimate, then saturate
	always_comb begin
		qm  = 32'(qq_s2) * Q_32PI;
		rem = 32'(diff_s2) - qm;
		if (rem < 0) e = qm - Q_32PI;
		else if (rem >= Q_32PI) e = qm + Q_32PI;
		else e = qm;
		d3 = d_s2 + e;
		if (d3 > ABS_MAX) d3 = ABS_MAX;
		if (d3 < ABS_MIN) d3 = ABS_MIN;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d0;
			ref_s1 <= 32'(sd.ref_ph);
			w_s1 <= 19'(w);
			sd_s1 <= sd;
			ok_s1 <= sd.msq > {thr_sq, 2'b00};
			ref_en_s1 <= ref_en;
			// stage 2: quotient estimate
			qq_s2 <= ref_en_s1 ? qq : '0;
			diff_s2 <= ref_en_s1 ? diff : '0;
			d_s2 <= d_s1;
			w_s2 <= w_s1;
			sd_s2 <= sd_s1;
			ok_s2 <= ok_s1;
			// stage 3: correct, saturate and mask
			abs_s3 <= ok_s2 ? 28'(d3) : '0;
			wrp_s3 <= w_s2;
			sum_s3 <= 10'(sd_s2.sum);
			msq_s3 <= 17'(sd_s2.msq);
			ok_s3 <= ok_s2;
		end
	end
endmodule

FILE: rtl/core/phase_shift_gray_code_unwrap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_shift_gray_code_unwrap_top
// Four-step phase shift plus complementary Gray code absolute phase.
//
// pix_in carries one pixel per transaction (four phase samples, six Gray
// samples, reference phase); res_out carries one result per pixel in order.
// Configuration: cfg_we/cfg_idx/cfg_wdata; index 0 is the modulation
// threshold (reset 5), index 1 the reference enable (reset 0).
// Accepts one pixel per cycle while res_out is not stalled. Results pass
// the front stage, the 24 CORDIC cells and three back-end stages.
// The whole pipeline advances as one; when res_out stalls with a result
// waiting, every stage holds and pix_in.ready drops. Reset empties the
// pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module phase_shift_gray_code_unwrap_top import psgc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_wdata,
	psgc_in_if.sink    pix_in,
	psgc_out_if.source res_out
);
	logic [7:0] thr_q;
	logic       ref_en_q;
	logic       en;
	pixel_t     px;
	logic       v [CORDIC_STEPS+1];
	cordic_t    c [CORDIC_STEPS+1];
	side_t      s [CORDIC_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 8'd5;
			ref_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_THRESHOLD:  thr_q <= cfg_wdata;
				REG_REF_ENABLE: ref_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign en = !res_out.valid || res_out.ready;
	assign pix_in.ready = en;
	assign px.ps = {pix_in.phase_sample_3, pix_in.phase_sample_2,
		pix_in.phase_sample_1, pix_in.phase_sample_0};
	assign px.gs = {pix_in.gray_sample_5, pix_in.gray_sample_4, pix_in.gray_sample_3,
		pix_in.gray_sample_2, pix_in.gray_sample_1, pix_in.gray_sample_0};
	assign px.ref_ph = pix_in.ref_phase;

	psgc_front u_front (.clk, .arst_n, .en, .vld_in(pix_in.valid), .px,
		.vld_s1(v[0]), .cd_s1(c[0]), .sd_s1(s[0]));

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		psgc_cell u_cell (.clk, .arst_n, .en, .step(5'(i)), .vld_in(v[i]),
			.cd_in(c[i]), .sd_in(s[i]), .vld_q(v[i+1]), .cd_q(c[i+1]), .sd_q(s[i+1]));
	end

	psgc_back u_back (.clk, .arst_n, .en, .vld_in(v[CORDIC_STEPS]),
		.cd(c[CORDIC_STEPS]), .sd(s[CORDIC_STEPS]), .thr(thr_q), .ref_en(ref_en_q),
		.vld_s3(res_out.valid), .abs_s3(res_out.absolute_phase),
		.wrp_s3(res_out.wrapped_phase), .sum_s3(res_out.texture_sum),
		.msq_s3(res_out.modulation_sq), .ok_s3(res_out.modulation_ok));
endmodule

FILE: rtl/core/psgc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgc_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module psgc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [27:0] out_abs,
	input logic        out_ok
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_abs)) else $error("result dropped");
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ok |-> out_abs == 28'd0) else $error("masked phase not zero");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("accept during stall");
endmodule

bind phase_shift_gray_code_unwrap_top psgc_checker u_chk (.clk, .arst_n,
	.in_ready(pix_in.ready), .out_valid(res_out.valid), .out_ready(res_out.ready),
	.out_abs(res_out.absolute_phase), .out_ok(res_out.modulation_ok));
